// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define TLD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define TLD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/tld_pkg.sv =====
// Shared types, codes and constants of the terminal line discipline.
package tld_pkg;

  localparam int DEPTH_DEFAULT = 128;
  localparam int APB_DATA_W    = 32;
  localparam int APB_ADDR_W    = 4;

  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_EOF = 8'h04;
  localparam logic [7:0] CH_DEL = 8'h7F;
  localparam logic [7:0] CH_NUL = 8'h00;

  typedef enum logic [1:0] {
    ACT_RX   = 2'd0,
    ACT_POP  = 2'd1,
    ACT_TX   = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_TX    = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_EMPTY = 2'd2,
    KIND_EOF   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_CANON = 2'd0,
    REG_ECHO  = 2'd1,
    REG_CRLF  = 2'd2,
    REG_ADDCR = 2'd3
  } reg_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  typedef struct packed {
    logic canon;
    logic echo;
    logic cr_to_lf;
    logic add_cr;
  } cfg_t;

  typedef struct packed {
    logic       load;
    kind_t      kind;
    logic [1:0] count;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic       line_end;
  } res_t;

endpackage

// ===== rtl/tld_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
module tld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/tld_emit.sv =====
// Result buffer that hands out up to three results of one item, one per transfer.
module tld_emit (
  input  logic          clk,
  input  logic          rst,
  input  tld_pkg::res_t res,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [1:0]    kind,
  output logic [7:0]    byte_out,
  output logic          line_end,
  output logic          last,
  output logic          busy
);

  import tld_pkg::*;

  logic       active;
  logic [1:0] pos;
  logic [1:0] count;
  kind_t      kind_q;
  logic [7:0] bytes [3];
  logic       le_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      pos    <= 2'd0;
    end else if (res.load) begin
      active <= 1'b1;
      pos    <= 2'd0;
    end else if (active && !out_stall) begin
      if (last) begin
        active <= 1'b0;
      end else begin
        pos <= pos + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      count    <= res.count;
      kind_q   <= res.kind;
      bytes[0] <= res.b0;
      bytes[1] <= res.b1;
      bytes[2] <= res.b2;
      le_q     <= res.line_end;
    end
  end

  always_comb begin
    unique case (pos)
      2'd0:    byte_out = bytes[0];
      2'd1:    byte_out = bytes[1];
      default: byte_out = bytes[2];
    endcase
  end

  assign out_valid = active;
  assign busy      = active;
  assign kind      = kind_q;
  assign line_end  = le_q;
  assign last      = (pos == count - 2'd1);

endmodule

// ===== rtl/tld_ctrl.sv =====
// Sequencer that edits the indices and reads and writes the line store.
module tld_ctrl #(
  parameter int BUFFER_DEPTH = tld_pkg::DEPTH_DEFAULT,
  localparam int IDX_W  = $clog2(2 * BUFFER_DEPTH),
  localparam int SLOT_W = $clog2(BUFFER_DEPTH)
) (
  input  logic              clk,
  input  logic              rst,
  input  tld_pkg::cfg_t     cfg,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        action,
  input  logic [7:0]        char_in,
  input  logic              first_of_read,
  input  logic              emit_busy,
  output logic              we,
  output logic [SLOT_W-1:0] waddr,
  output logic [7:0]        wdata,
  output logic [SLOT_W-1:0] raddr,
  input  logic [7:0]        rdata,
  output tld_pkg::res_t     res
);

  import tld_pkg::*;

  localparam logic [IDX_W:0] SPAN  = (IDX_W + 1)'(2 * BUFFER_DEPTH);
  localparam logic [IDX_W:0] DEPTH = (IDX_W + 1)'(BUFFER_DEPTH);

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
    logic [IDX_W:0] s;
    s = {1'b0, i} + 1'b1;
    return (s == SPAN) ? '0 : s[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
    logic [IDX_W:0] s;
    s = SPAN - 1'b1;
    return (i == '0) ? s[IDX_W-1:0] : i - 1'b1;
  endfunction

  function automatic logic [SLOT_W-1:0] idx_slot(input logic [IDX_W-1:0] i);
    logic [IDX_W:0] s;
    s = ({1'b0, i} >= DEPTH) ? {1'b0, i} - DEPTH : {1'b0, i};
    return s[SLOT_W-1:0];
  endfunction

  state_t           state, state_next;
  logic [IDX_W-1:0] read_index, read_index_next;
  logic [IDX_W-1:0] commit_index, commit_index_next;
  logic [IDX_W-1:0] edit_index, edit_index_next;
  logic             first_q;
  logic             accept;
  logic [IDX_W:0]   fill_sum;
  logic [IDX_W:0]   fill;
  logic [7:0]       c_map;
  logic [7:0]       send_char;
  logic             send_on;

  assign in_stall = (state != ST_IDLE) || emit_busy;
  assign accept   = in_valid && !in_stall;

  assign fill_sum = {1'b0, edit_index} + SPAN - {1'b0, read_index};
  assign fill     = (fill_sum >= SPAN) ? fill_sum - SPAN : fill_sum;
  assign c_map    = (cfg.cr_to_lf && char_in == CH_CR) ? CH_LF : char_in;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && action_t'(action) == ACT_POP && read_index != commit_index) begin
          state_next = ST_READ;
        end
      end
      ST_READ: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    we                = 1'b0;
    waddr             = idx_slot(edit_index);
    wdata             = c_map;
    raddr             = idx_slot(read_index);
    read_index_next   = read_index;
    commit_index_next = commit_index;
    edit_index_next   = edit_index;
    res               = '0;
    send_on           = 1'b0;
    send_char         = char_in;
    if (state == ST_READ) begin
      read_index_next = idx_inc(read_index);
      res.load        = 1'b1;
      res.count       = 2'd1;
      if (rdata == CH_EOF) begin
        if (!first_q) begin
          read_index_next = read_index;
        end
        res.kind = KIND_EOF;
      end else begin
        res.kind     = KIND_DATA;
        res.b0       = rdata;
        res.line_end = cfg.canon && rdata == CH_LF;
      end
    end else if (accept) begin
      unique case (action_t'(action))
        ACT_RX: begin
          if (cfg.canon && char_in == CH_DEL) begin
            if (edit_index != commit_index) begin
              edit_index_next = idx_dec(edit_index);
              if (cfg.echo) begin
                res.load  = 1'b1;
                res.kind  = KIND_TX;
                res.count = 2'd3;
                res.b0    = CH_BS;
                res.b1    = CH_SP;
                res.b2    = CH_BS;
              end
            end
          end else if (!(cfg.canon && char_in == CH_BS) && char_in != CH_NUL
                       && fill < DEPTH) begin
            we              = 1'b1;
            edit_index_next = idx_inc(edit_index);
            if (!cfg.canon || c_map == CH_LF || c_map == CH_EOF || fill == DEPTH - 1'b1) begin
              commit_index_next = idx_inc(edit_index);
            end
            send_on   = cfg.echo;
            send_char = c_map;
          end
        end
        ACT_POP: begin
          if (read_index == commit_index) begin
            res.load  = 1'b1;
            res.kind  = KIND_EMPTY;
            res.count = 2'd1;
          end
        end
        ACT_TX:   send_on = 1'b1;
        ACT_NONE: send_on = 1'b0;
        default:  send_on = 1'b0;
      endcase
      if (send_on) begin
        res.load = 1'b1;
        res.kind = KIND_TX;
        if (cfg.add_cr && send_char == CH_LF) begin
          res.count = 2'd2;
          res.b0    = CH_CR;
          res.b1    = CH_LF;
        end else begin
          res.count = 2'd1;
          res.b0    = send_char;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      read_index   <= '0;
      commit_index <= '0;
      edit_index   <= '0;
    end else begin
      state        <= state_next;
      read_index   <= read_index_next;
      commit_index <= commit_index_next;
      edit_index   <= edit_index_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      first_q <= first_of_read;
    end
  end

endmodule

// ===== rtl/tty_line_discipline_buffer_top.sv =====
// Top level of the terminal line discipline: register port, sequencer, store and results.
//
// Canonical terminal line discipline. Received bytes are edited into a circular line store
// of BUFFER_DEPTH bytes held in one synchronous RAM; read pops drain committed bytes and
// transmit bytes pass out with CR added before LF. One item is worked on at a time. An item
// passes through the sequencer, a read pop of a non-empty store also through the RAM's
// registered read, and then each of its zero to three results takes one output transfer;
// the next item is taken in the cycle after the last result of the previous one is
// transferred. CR is added before LF only when add_cr is set. The store needs no clearing
// after reset.
module tty_line_discipline_buffer_top #(
  parameter int BUFFER_DEPTH = tld_pkg::DEPTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tld_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [tld_pkg::APB_DATA_W-1:0] pwdata,
  output logic [tld_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     action,
  input  logic [7:0]                     char_in,
  input  logic                           first_of_read,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     kind,
  output logic [7:0]                     byte_out,
  output logic                           line_end,
  output logic                           last
);

  import tld_pkg::*;

  localparam int SLOT_W = $clog2(BUFFER_DEPTH);

  cfg_t              cfg;
  logic              cfg_write;
  logic              rd_bit;
  res_t              res;
  logic              emit_busy;
  logic              we;
  logic [SLOT_W-1:0] waddr;
  logic [7:0]        wdata;
  logic [SLOT_W-1:0] raddr;
  logic [7:0]        rdata;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{canon: 1'b1, echo: 1'b1, cr_to_lf: 1'b1, add_cr: 1'b1};
    end else if (cfg_write) begin
      unique case (reg_t'(paddr[3:2]))
        REG_CANON: cfg.canon    <= pwdata[0];
        REG_ECHO:  cfg.echo     <= pwdata[0];
        REG_CRLF:  cfg.cr_to_lf <= pwdata[0];
        REG_ADDCR: cfg.add_cr   <= pwdata[0];
        default:   cfg.canon    <= cfg.canon;
      endcase
    end
  end

  always_comb begin
    unique case (reg_t'(paddr[3:2]))
      REG_CANON: rd_bit = cfg.canon;
      REG_ECHO:  rd_bit = cfg.echo;
      REG_CRLF:  rd_bit = cfg.cr_to_lf;
      REG_ADDCR: rd_bit = cfg.add_cr;
      default:   rd_bit = 1'b0;
    endcase
  end

  assign prdata = {{(APB_DATA_W - 1){1'b0}}, rd_bit};

  tld_ctrl #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .char_in      (char_in),
    .first_of_read(first_of_read),
    .emit_busy    (emit_busy),
    .we           (we),
    .waddr        (waddr),
    .wdata        (wdata),
    .raddr        (raddr),
    .rdata        (rdata),
    .res          (res)
  );

  tld_ram #(
    .WIDTH(8),
    .DEPTH(BUFFER_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  tld_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .res      (res),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .kind     (kind),
    .byte_out (byte_out),
    .line_end (line_end),
    .last     (last),
    .busy     (emit_busy)
  );

endmodule

// ===== rtl/tld_checker.sv =====
// Port-level checker of the terminal line discipline and its bind to the top level.
`include "assert_macros.svh"

module tld_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [1:0] action,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] kind,
  input logic [7:0] byte_out,
  input logic       line_end,
  input logic       last
);

  import tld_pkg::*;

  logic        in_xfer;
  logic        out_xfer;
  logic        out_held;
  logic        has_result;
  logic [11:0] out_word;

  assign in_xfer    = in_valid && !in_stall;
  assign out_xfer   = out_valid && !out_stall;
  assign out_held   = out_valid && out_stall;
  assign has_result = (action == ACT_POP) || (action == ACT_TX);
  assign out_word   = {kind, byte_out, line_end, last};

  `TLD_ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable(out_word), "held result changed")
  `TLD_ASSERT_SAME(a_read_single, out_valid && kind != KIND_TX, last, "read result not alone")
  `TLD_ASSERT_NEXT(a_pop_busy, in_xfer && has_result, in_stall, "next item not held off")
  `TLD_ASSERT_NEXT(a_burst, out_xfer && !last, out_valid, "results not back to back")

endmodule

bind tty_line_discipline_buffer_top tld_checker u_tld_checker (.*);

// ===== bench/testbench.sv =====
// Self-checking testbench for the terminal line discipline buffer top level.
module testbench;
  import tld_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 10;

  typedef struct {
    kind_t      kind;
    logic [7:0] data;
    logic       line_end;
    logic       last;
  } tty_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [1:0]            action = ACT_NONE;
  logic [7:0]            char_in = '0;
  logic                  first_of_read = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [1:0]            kind;
  logic [7:0]            byte_out;
  logic                  line_end;
  logic                  last;

  logic        steady = 1'b0;
  int          hold_len = 0;
  int          idle_cycles = 0;
  int          mismatches = 0;
  int          items_sent = 0;

  logic [7:0]  line_mem [DEPTH_DEFAULT];
  logic [7:0]  rd_ix = '0;
  logic [7:0]  cm_ix = '0;
  logic [7:0]  ed_ix = '0;
  logic        cfg_canon = 1'b1;
  logic        cfg_echo = 1'b1;
  logic        cfg_crlf = 1'b1;
  logic        cfg_addcr = 1'b1;

  tty_result_t owed_q[$];
  tty_result_t step_q[$];

  tty_line_discipline_buffer_top u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .char_in(char_in), .first_of_read(first_of_read),
    .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .byte_out(byte_out), .line_end(line_end), .last(last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void owe(kind_t k, logic [7:0] d, logic le);
    tty_result_t r;
    r.kind = k;
    r.data = d;
    r.line_end = le;
    r.last = 1'b0;
    step_q.push_back(r);
  endfunction

  function automatic void owe_tx(logic [7:0] c);
    if (cfg_addcr && c == CH_LF) owe(KIND_TX, CH_CR, 1'b0);
    owe(KIND_TX, c, 1'b0);
  endfunction

  function automatic void receive_byte(logic [7:0] c_in);
    logic [7:0] c;
    c = c_in;
    if (cfg_canon && c == CH_BS) return;
    if (cfg_canon && c == CH_DEL) begin
      if (ed_ix != cm_ix) begin
        ed_ix = ed_ix - 8'd1;
        if (cfg_echo) begin
          owe(KIND_TX, CH_BS, 1'b0);
          owe(KIND_TX, CH_SP, 1'b0);
          owe(KIND_TX, CH_BS, 1'b0);
        end
      end
      return;
    end
    if (c == CH_NUL || (ed_ix - rd_ix) >= 8'(DEPTH_DEFAULT)) return;
    if (cfg_crlf && c == CH_CR) c = CH_LF;
    if (cfg_echo) owe_tx(c);
    line_mem[ed_ix[6:0]] = c;
    ed_ix = ed_ix + 8'd1;
    if (!cfg_canon || c == CH_LF || c == CH_EOF || (ed_ix - rd_ix) == 8'(DEPTH_DEFAULT))
      cm_ix = ed_ix;
  endfunction

  function automatic void pop_byte(logic first);
    logic [7:0] c;
    if (rd_ix == cm_ix) begin
      owe(KIND_EMPTY, 8'h00, 1'b0);
      return;
    end
    c = line_mem[rd_ix[6:0]];
    if (c == CH_EOF) begin
      if (first) rd_ix = rd_ix + 8'd1;
      owe(KIND_EOF, 8'h00, 1'b0);
      return;
    end
    rd_ix = rd_ix + 8'd1;
    owe(KIND_DATA, c, cfg_canon && c == CH_LF);
  endfunction

  function automatic void discipline_step(action_t a, logic [7:0] c, logic first);
    tty_result_t r;
    step_q.delete();
    case (a)
      ACT_RX: receive_byte(c);
      ACT_POP: pop_byte(first);
      ACT_TX: owe_tx(c);
      default: ;
    endcase
    foreach (step_q[i]) begin
      r = step_q[i];
      r.last = (i == step_q.size() - 1);
      owed_q.push_back(r);
    end
  endfunction

  task automatic offer_item(action_t a, logic [7:0] c, logic first);
    in_valid <= 1'b1;
    action <= a;
    char_in <= c;
    first_of_read <= first;
    do @(posedge clk); while (in_stall);
    discipline_step(a, c, first);
    if (a != ACT_NONE) items_sent++;
    if (!steady && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (owed_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_t r, logic v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= APB_DATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (r)
      REG_CANON: cfg_canon = v;
      REG_ECHO: cfg_echo = v;
      REG_CRLF: cfg_crlf = v;
      REG_ADDCR: cfg_addcr = v;
      default: ;
    endcase
  endtask

  task automatic write_all(logic canon, logic echo, logic crlf, logic addcr);
    write_reg(REG_CANON, canon);
    write_reg(REG_ECHO, echo);
    write_reg(REG_CRLF, crlf);
    write_reg(REG_ADDCR, addcr);
  endtask

  task automatic test_line_editing();
    offer_item(ACT_RX, 8'h61, 1'b0);
    offer_item(ACT_RX, 8'hFF, 1'b1);
    offer_item(ACT_RX, CH_NUL, 1'b0);
    offer_item(ACT_RX, CH_DEL, 1'b0);
    offer_item(ACT_RX, CH_BS, 1'b0);
    offer_item(ACT_RX, CH_CR, 1'b0);
    offer_item(ACT_POP, 8'h00, 1'b1);
    offer_item(ACT_POP, 8'hFF, 1'b0);
    offer_item(ACT_POP, 8'h00, 1'b1);
    offer_item(ACT_RX, CH_DEL, 1'b0);
    offer_item(ACT_RX, CH_EOF, 1'b0);
    offer_item(ACT_POP, 8'h00, 1'b0);
    offer_item(ACT_POP, 8'h00, 1'b1);
    offer_item(ACT_POP, 8'h00, 1'b0);
    offer_item(ACT_TX, CH_LF, 1'b0);
    offer_item(ACT_TX, 8'hFF, 1'b1);
    offer_item(ACT_NONE, 8'hFF, 1'b1);
    wait_drained();
  endtask

  task automatic test_raw_mode();
    write_all(1'b0, 1'b0, 1'b0, 1'b0);
    offer_item(ACT_RX, CH_DEL, 1'b0);
    offer_item(ACT_RX, CH_BS, 1'b0);
    offer_item(ACT_RX, CH_CR, 1'b0);
    offer_item(ACT_RX, CH_LF, 1'b0);
    repeat (5) offer_item(ACT_POP, 8'h00, 1'b1);
    offer_item(ACT_TX, CH_LF, 1'b0);
    wait_drained();
    write_reg(REG_ECHO, 1'b1);
    offer_item(ACT_RX, CH_LF, 1'b0);
    offer_item(ACT_POP, 8'h00, 1'b0);
    wait_drained();
  endtask

  task automatic test_full_store();
    write_all(1'b1, 1'b1, 1'b1, 1'b1);
    hold_len <= 300;
    repeat (DEPTH_DEFAULT + 2) offer_item(ACT_RX, 8'($urandom_range(8'h21, 8'h7E)), 1'b0);
    offer_item(ACT_RX, CH_DEL, 1'b0);
    wait_drained();
    repeat (DEPTH_DEFAULT + 1) offer_item(ACT_POP, 8'h00, 1'($urandom_range(0, 1)));
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int start_count;
    int phase_start;
    int len;
    int ph;
    logic [7:0] c;
    start_count = items_sent;
    ph = 0;
    while (items_sent - start_count < 120) begin
      wait_drained();
      if (ph == 0) write_all(1'b1, 1'b1, 1'b1, 1'b1);
      else if (ph == 1) write_all(1'b0, 1'b0, 1'b0, 1'b0);
      else write_all(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      steady = (ph == 2);
      phase_start = items_sent;
      while (items_sent - phase_start < 25) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5, 6: begin
            len = $urandom_range(0, 6);
            repeat (len) begin
              if (cfg_canon && $urandom_range(0, 9) == 0) c = CH_DEL;
              else c = 8'($urandom_range(1, 255));
              offer_item(ACT_RX, c, 1'($urandom_range(0, 1)));
            end
            case ($urandom_range(0, 2))
              0: c = CH_LF;
              1: c = CH_CR;
              default: c = CH_EOF;
            endcase
            offer_item(ACT_RX, c, 1'($urandom_range(0, 1)));
            for (int k = 0; k < len + 2; k++)
              offer_item(ACT_POP, 8'($urandom_range(0, 255)),
                         (k == 0) ? 1'b1 : 1'($urandom_range(0, 1)));
          end
          7, 8: offer_item(ACT_TX, ($urandom_range(0, 3) == 0) ? CH_LF :
                           8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
          default: offer_item(action_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)));
        endcase
      end
      ph++;
    end
    steady = 1'b0;
    wait_drained();
  endtask

  always @(posedge clk) begin
    if (hold_len != 0) begin
      out_stall <= 1'b1;
      hold_len <= hold_len - 1;
    end else if (steady) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 25);
    end
  end

  always @(posedge clk) begin
    tty_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (owed_q.size() == 0) begin
        $display("%0t: unexpected result: kind %0d byte %h line_end %b last %b",
                 $time, kind, byte_out, line_end, last);
        mismatches++;
      end else begin
        e = owed_q.pop_front();
        if (kind !== e.kind || byte_out !== e.data || line_end !== e.line_end ||
            last !== e.last) begin
          $display("%0t: mismatch: expected kind %0d byte %h line_end %b last %b", $time,
                   e.kind, e.data, e.line_end, e.last);
          $display("%0t:           actual kind %0d byte %h line_end %b last %b", $time,
                   kind, byte_out, line_end, last);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_line_editing();
    test_raw_mode();
    test_full_store();
    test_random_traffic();
    if (mismatches == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
